/* design/balanced_ternary_stitch_codec_defines.svh */
// Assertion macros for the stitch codec.
`ifndef BALANCED_TERNARY_STITCH_CODEC_DEFINES_SVH
`define BALANCED_TERNARY_STITCH_CODEC_DEFINES_SVH

`ifndef SYNTH
`define BTSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stitch codec check failed");
`define BTSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stitch codec check failed");
`else
`define BTSC_ASSERT_NOW(lbl, ante, cons)
`define BTSC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* design/btsc_pkg.sv */
package btsc_pkg;

  localparam logic signed [8:0] W81 = 9'sd81;
  localparam logic signed [8:0] W27 = 9'sd27;
  localparam logic signed [8:0] W9  = 9'sd9;
  localparam logic signed [8:0] W3  = 9'sd3;
  localparam logic signed [8:0] W1  = 9'sd1;

  localparam logic signed [7:0] DISP_LIMIT = 8'sd121;

  localparam logic [7:0] REC_END  = 8'hF3;
  localparam logic [7:0] REC_STOP = 8'hC3;
  localparam logic [7:0] REC_TRIM = 8'h83;
  localparam logic [7:0] REC_BASE = 8'h03;

  localparam int FLAG_END  = 0;
  localparam int FLAG_JUMP = 1;
  localparam int FLAG_TRIM = 2;
  localparam int FLAG_STOP = 3;

  localparam logic [1:0] KIND_NORMAL = 2'd0;
  localparam logic [1:0] KIND_TRIM   = 2'd1;
  localparam logic [1:0] KIND_STOP   = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  typedef struct packed {
    logic                plus;
    logic                minus;
    logic signed [8:0]   rest;
  } digit_t;

  // One greedy balanced-ternary digit: round the residue to the nearest weight.
  function automatic digit_t digit_step(input logic signed [8:0] v,
                                        input logic signed [8:0] w);
    logic signed [8:0] half;
    digit_t d;
    half = (w + 9'sd1) >>> 1;
    d.plus  = 1'b0;
    d.minus = 1'b0;
    d.rest  = v;
    if (v >= half) begin
      d.plus = 1'b1;
      d.rest = v - w;
    end else if (v <= -half) begin
      d.minus = 1'b1;
      d.rest  = v + w;
    end
    return d;
  endfunction

  // Both bits set cancel out.
  function automatic logic signed [8:0] digit_val(input logic p, input logic m,
                                                  input logic signed [8:0] w);
    logic signed [8:0] r;
    r = 9'sd0;
    if (p && !m) begin
      r = w;
    end else if (m && !p) begin
      r = -w;
    end
    return r;
  endfunction

  function automatic logic [1:0] classify(input logic [7:0] b2);
    logic [1:0] k;
    if (b2 == REC_END) begin
      k = KIND_END;
    end else if ((b2 & REC_STOP) == REC_TRIM) begin
      k = KIND_TRIM;
    end else if ((b2 & REC_STOP) == REC_STOP) begin
      k = KIND_STOP;
    end else begin
      k = KIND_NORMAL;
    end
    return k;
  endfunction

endpackage

/* design/balanced_ternary_stitch_codec.sv */
// Balanced-ternary stitch record codec, three register stages.
// An accepted input word passes through the stage 1, stage 2 and output registers in turn
// (the first stage loads on the accepting edge) before its output word is valid.
// Throughput: one word per cycle; a stall holds each full stage until the next one frees.
// Reset (rst, synchronous): empties the pipeline and sets decode_mode to encode.
// decode_mode is sampled with each input word as it enters.
`include "balanced_ternary_stitch_codec_defines.svh"

module balanced_ternary_stitch_codec
  import btsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,      // decode_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // dx_in[7:0], dy_in[15:8], in_byte0[23:16], in_byte1[31:24], in_byte2[39:32]
  input  logic [39:0] s_axis_tdata,
  input  logic [3:0]  s_axis_tuser,   // stitch_flags[3:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_byte0[7:0], out_byte1[15:8], out_byte2[23:16], encode_ok[24],
  // dx_out[32:25], dy_out[40:33], zero[47:41]
  output logic [47:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser   // stitch_kind[1:0]
);

  logic decode_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode <= 1'b0;
    end else if (cfg_we) begin
      decode_mode <= cfg_wdata;
    end
  end

  // Flow control
  logic out_free, s2_free, s1_free;
  logic s1_valid, s2_valid;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s2_free       = !s2_valid || out_free;
  assign s1_free       = !s1_valid || s2_free;
  assign s_axis_tready = s1_free;

  // Stage 1: range check, heavy digits, kind
  logic signed [7:0] x_in, y_in;
  logic signed [8:0] x_ext, y_ext;
  digit_t x81, x27, y81, y27;
  logic in_ok;

  assign x_in  = $signed(s_axis_tdata[7:0]);
  assign y_in  = $signed(s_axis_tdata[15:8]);
  assign x_ext = 9'(x_in);
  assign y_ext = 9'(y_in);
  assign in_ok = (x_in <= DISP_LIMIT) && (x_in >= -DISP_LIMIT) &&
                 (y_in <= DISP_LIMIT) && (y_in >= -DISP_LIMIT);

  always_comb begin
    x81 = digit_step(x_ext, W81);
    x27 = digit_step(x81.rest, W27);
    y81 = digit_step(y_ext, W81);
    y27 = digit_step(y81.rest, W27);
  end

  logic              s1_mode, s1_ok;
  logic [3:0]        s1_flags;
  logic signed [5:0] s1_xr, s1_yr;
  logic [3:0]        s1_xd, s1_yd;   // {p81, m81, p27, m27}
  logic [7:0]        s1_b0, s1_b1, s1_b2;
  logic [1:0]        s1_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= s_axis_tvalid;
    end
    if (s1_free) begin
      s1_mode  <= decode_mode;
      s1_ok    <= in_ok;
      s1_flags <= s_axis_tuser;
      s1_xr    <= 6'(x27.rest);
      s1_yr    <= 6'(y27.rest);
      s1_xd    <= {x81.plus, x81.minus, x27.plus, x27.minus};
      s1_yd    <= {y81.plus, y81.minus, y27.plus, y27.minus};
      s1_b0    <= s_axis_tdata[23:16];
      s1_b1    <= s_axis_tdata[31:24];
      s1_b2    <= s_axis_tdata[39:32];
      s1_kind  <= classify(s_axis_tdata[39:32]);
    end
  end

  // Stage 2: light digits and record bits, or decoded sums
  digit_t x9, x3, x1, y9, y3, y1;
  logic [7:0] e0, e1, e2;
  logic signed [8:0] dx_sum, dy_sum;

  always_comb begin
    x9 = digit_step(9'(s1_xr), W9);
    x3 = digit_step(x9.rest, W3);
    x1 = digit_step(x3.rest, W1);
    y9 = digit_step(9'(s1_yr), W9);
    y3 = digit_step(y9.rest, W3);
    y1 = digit_step(y3.rest, W1);

    e0 = {y1.plus, y1.minus, y9.plus, y9.minus, x9.minus, x9.plus, x1.minus, x1.plus};
    e1 = {y3.plus, y3.minus, s1_yd[1], s1_yd[0], s1_xd[0], s1_xd[1], x3.minus, x3.plus};
    e2 = {2'b00, s1_yd[3], s1_yd[2], s1_xd[2], s1_xd[3], 2'b00};

    dx_sum = digit_val(s1_b0[0], s1_b0[1], W1) + digit_val(s1_b1[0], s1_b1[1], W3) +
             digit_val(s1_b0[2], s1_b0[3], W9) + digit_val(s1_b1[2], s1_b1[3], W27) +
             digit_val(s1_b2[2], s1_b2[3], W81);
    dy_sum = digit_val(s1_b0[7], s1_b0[6], W1) + digit_val(s1_b1[7], s1_b1[6], W3) +
             digit_val(s1_b0[5], s1_b0[4], W9) + digit_val(s1_b1[5], s1_b1[4], W27) +
             digit_val(s1_b2[5], s1_b2[4], W81);
  end

  logic              s2_mode, s2_ok;
  logic [3:0]        s2_flags;
  logic [7:0]        s2_r0, s2_r1, s2_r2;
  logic signed [7:0] s2_dx, s2_dy;
  logic [1:0]        s2_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
    if (s2_free) begin
      s2_mode  <= s1_mode;
      s2_ok    <= s1_ok;
      s2_flags <= s1_flags;
      s2_r0    <= e0;
      s2_r1    <= e1;
      s2_r2    <= e2;
      s2_dx    <= 8'(dx_sum);
      s2_dy    <= 8'(dy_sum);
      s2_kind  <= s1_kind;
    end
  end

  // Stage 3: flags, rejection, unused fields zeroed
  logic [7:0]        o0, o1, o2;
  logic              o_ok;
  logic signed [7:0] o_dx, o_dy;
  logic [1:0]        o_kind;

  always_comb begin
    o0     = 8'h00;
    o1     = 8'h00;
    o2     = 8'h00;
    o_ok   = 1'b0;
    o_dx   = 8'sd0;
    o_dy   = 8'sd0;
    o_kind = KIND_NORMAL;
    if (s2_mode) begin
      o_dx   = s2_dx;
      o_dy   = s2_dy;
      o_kind = s2_kind;
    end else if (s2_ok) begin
      o_ok = 1'b1;
      o0   = s2_r0;
      o1   = s2_r1;
      o2   = s2_r2 | REC_BASE;
      if (s2_flags[FLAG_END]) begin
        o0 = 8'h00;
        o1 = 8'h00;
        o2 = REC_END;
      end
      if (s2_flags[FLAG_JUMP] || s2_flags[FLAG_TRIM]) begin
        o2 = o2 | REC_TRIM;
      end
      if (s2_flags[FLAG_STOP]) begin
        o2 = o2 | REC_STOP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= s2_valid;
    end
    if (out_free) begin
      m_axis_tdata <= {7'd0, o_dy, o_dx, o_ok, o2, o1, o0};
      m_axis_tuser <= o_kind;
    end
  end

  `BTSC_ASSERT_NOW(a_idle_ready, !s1_valid, s_axis_tready)
  `BTSC_ASSERT_NEXT(a_s1_hold, s1_valid && !s2_free, s1_valid && $stable(s1_b2) && $stable(s1_xr))
  `BTSC_ASSERT_NOW(a_ok_no_decode, m_axis_tvalid && m_axis_tdata[24],
                   m_axis_tuser == KIND_NORMAL && m_axis_tdata[40:25] == 16'd0)
  `BTSC_ASSERT_NOW(a_ok_base_bits, m_axis_tvalid && m_axis_tdata[24],
                   m_axis_tdata[17:16] == 2'b11)

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import btsc_pkg::*;

  localparam bit MODE_ENCODE = 1'b0;
  localparam bit MODE_DECODE = 1'b1;

  localparam logic [3:0] F_END  = 4'(1 << FLAG_END);
  localparam logic [3:0] F_JUMP = 4'(1 << FLAG_JUMP);
  localparam logic [3:0] F_TRIM = 4'(1 << FLAG_TRIM);
  localparam logic [3:0] F_STOP = 4'(1 << FLAG_STOP);

  // Digit weights, heaviest first, and the plus bit of each digit in the
  // 24-bit record {byte2, byte1, byte0}. The x minus bit sits one above its
  // plus bit, the y minus bit one below.
  localparam int DIGIT_WEIGHT [5] = '{81, 27, 9, 3, 1};
  localparam int X_PLUS_BIT [5]   = '{18, 10, 2, 8, 0};
  localparam int Y_PLUS_BIT [5]   = '{21, 13, 5, 15, 7};
  localparam int DISP_EXTREMES [7] = '{-128, -122, -121, 0, 121, 122, 127};

  localparam int RANDOM_PER_PHASE = 178;
  localparam int PIPE_DRAIN       = 8;
  localparam int QUIET_LIMIT      = 1000;
  localparam int HOLD_CYCLES      = 80;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
  localparam int SEND_GAP_PCT [4]   = '{0, 45, 0, 7};
  localparam int RECV_STALL_PCT [4] = '{0, 0, 45, 7};

  typedef struct packed {
    logic signed [7:0] dx;
    logic signed [7:0] dy;
    logic [3:0]        flags;
    logic [7:0]        b0;
    logic [7:0]        b1;
    logic [7:0]        b2;
  } stitch_word_t;

  typedef struct packed {
    logic [7:0]        ob0;
    logic [7:0]        ob1;
    logic [7:0]        ob2;
    logic              ok;
    logic signed [7:0] dxo;
    logic signed [7:0] dyo;
    logic [6:0]        spare;
    logic [1:0]        kind;
  } stitch_record_t;

  class codec_scoreboard;
    stitch_record_t pending_records[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function logic [23:0] place_digits(logic [23:0] rec, int v, bit y_axis);
      int half;
      int p;
      for (int i = 0; i < 5; i++) begin
        half = (DIGIT_WEIGHT[i] + 1) / 2;
        p = y_axis ? Y_PLUS_BIT[i] : X_PLUS_BIT[i];
        if (v >= half) begin
          rec[p] = 1'b1;
          v -= DIGIT_WEIGHT[i];
        end else if (v <= -half) begin
          rec[y_axis ? p - 1 : p + 1] = 1'b1;
          v += DIGIT_WEIGHT[i];
        end
      end
      return rec;
    endfunction

    function int sum_digits(logic [23:0] rec, bit y_axis);
      int v;
      int p;
      v = 0;
      for (int i = 0; i < 5; i++) begin
        p = y_axis ? Y_PLUS_BIT[i] : X_PLUS_BIT[i];
        if (rec[p]) v += DIGIT_WEIGHT[i];
        if (rec[y_axis ? p - 1 : p + 1]) v -= DIGIT_WEIGHT[i];
      end
      return v;
    endfunction

    function stitch_record_t convert_word(stitch_word_t w, bit mode);
      stitch_record_t r;
      logic [23:0] rec;
      int x;
      int y;
      r = '0;
      if (mode == MODE_ENCODE) begin
        x = int'(w.dx);
        y = int'(w.dy);
        if (x > int'(DISP_LIMIT) || x < -int'(DISP_LIMIT) ||
            y > int'(DISP_LIMIT) || y < -int'(DISP_LIMIT)) begin
          return r;
        end
        rec = place_digits(24'd0, x, 1'b0);
        rec = place_digits(rec, y, 1'b1);
        rec[23:16] |= REC_BASE;
        if (w.flags & F_END) rec = {REC_END, 16'h0000};
        if (w.flags & (F_JUMP | F_TRIM)) rec[23:16] |= REC_TRIM;
        if (w.flags & F_STOP) rec[23:16] |= REC_STOP;
        {r.ob2, r.ob1, r.ob0} = rec;
        r.ok = 1'b1;
      end else begin
        rec = {w.b2, w.b1, w.b0};
        r.dxo = 8'(sum_digits(rec, 1'b0));
        r.dyo = 8'(sum_digits(rec, 1'b1));
        if (w.b2 == REC_END) begin
          r.kind = KIND_END;
        end else if ((w.b2 & REC_STOP) == REC_TRIM) begin
          r.kind = KIND_TRIM;
        end else if ((w.b2 & REC_STOP) == REC_STOP) begin
          r.kind = KIND_STOP;
        end else begin
          r.kind = KIND_NORMAL;
        end
      end
      return r;
    endfunction

    function void note_word(stitch_word_t w, bit mode);
      pending_records.push_back(convert_word(w, mode));
    endfunction

    function void check_record(stitch_record_t got);
      stitch_record_t want;
      if (pending_records.size() == 0) begin
        if (errors < 10) $display("unexpected output word %h", got);
        errors++;
        return;
      end
      want = pending_records.pop_front();
      if (got.ob0 !== want.ob0 || got.ob1 !== want.ob1 || got.ob2 !== want.ob2 ||
          got.ok !== want.ok || got.dxo !== want.dxo || got.dyo !== want.dyo ||
          got.spare !== want.spare || got.kind !== want.kind) begin
        if (errors < 10) begin
          $display("mismatch exp: bytes %h %h %h ok %b dx %0d dy %0d kind %0d spare %h",
                   want.ob0, want.ob1, want.ob2, want.ok, want.dxo, want.dyo,
                   want.kind, want.spare);
          $display("         got: bytes %h %h %h ok %b dx %0d dy %0d kind %0d spare %h",
                   got.ob0, got.ob1, got.ob2, got.ok, got.dxo, got.dyo,
                   got.kind, got.spare);
        end
        errors++;
      end
    endfunction

    function bit all_matched();
      if (pending_records.size() != 0) begin
        $display("%0d output words never arrived", pending_records.size());
        errors++;
      end
      return errors == 0;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  codec_scoreboard sb = new();
  bit              codec_mode = MODE_ENCODE;
  idle_mode_t      idle_profile = IDLE_NONE;
  bit              hold_request = 1'b0;
  int              quiet_cycles = 0;

  balanced_ternary_stitch_codec i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    stitch_word_t w;
    stitch_record_t r;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      {w.b2, w.b1, w.b0, w.dy, w.dx} = s_axis_tdata;
      w.flags = s_axis_tuser;
      sb.note_word(w, codec_mode);
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      r.ob0   = m_axis_tdata[7:0];
      r.ob1   = m_axis_tdata[15:8];
      r.ob2   = m_axis_tdata[23:16];
      r.ok    = m_axis_tdata[24];
      r.dxo   = m_axis_tdata[32:25];
      r.dyo   = m_axis_tdata[40:33];
      r.spare = m_axis_tdata[47:41];
      r.kind  = m_axis_tuser;
      sb.check_record(r);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= RECV_STALL_PCT[idle_profile]);
      end
    end
  end

  // Valid stays high straight into the next word unless a gap is drawn.
  task automatic send_word(input stitch_word_t w);
    while ($urandom_range(0, 99) < SEND_GAP_PCT[idle_profile]) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w.b2, w.b1, w.b0, w.dy, w.dx};
    s_axis_tuser  <= w.flags;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_encode(input int x, input int y, input logic [3:0] f);
    stitch_word_t w;
    w.dx = 8'(x);
    w.dy = 8'(y);
    w.flags = f;
    w.b0 = 8'($urandom);
    w.b1 = 8'($urandom);
    w.b2 = 8'($urandom);
    send_word(w);
  endtask

  task automatic send_decode(input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2);
    stitch_word_t w;
    w.dx = 8'($urandom);
    w.dy = 8'($urandom);
    w.flags = 4'($urandom);
    w.b0 = b0;
    w.b1 = b1;
    w.b2 = b2;
    send_word(w);
  endtask

  task automatic write_mode(input bit mode);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
    codec_mode = mode;
  endtask

  function automatic int random_disp();
    case ($urandom_range(0, 9))
      0: return DISP_EXTREMES[$urandom_range(0, 6)];
      1: return int'($urandom_range(0, 255)) - 128;
      default: return int'($urandom_range(0, 242)) - 121;
    endcase
  endfunction

  initial begin : stimulus
    stitch_word_t w;
    stitch_record_t r;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 8; p++) begin
      idle_profile = idle_mode_t'(p / 2);
      write_mode((p % 2) ? MODE_DECODE : MODE_ENCODE);
      if (p == 0) begin
        send_encode(0, 0, 4'd0);
        send_encode(121, -121, 4'd0);
        send_encode(-121, 121, 4'd0);
        send_encode(122, 0, 4'd0);
        send_encode(0, -122, 4'd0);
        send_encode(127, -128, 4'd0);
        send_encode(1, -1, F_END);
        send_encode(5, 7, F_JUMP);
        send_encode(-40, 60, F_TRIM);
        send_encode(100, -100, F_STOP);
        send_encode(13, -13, 4'hF);
        send_encode(121, 121, F_JUMP | F_STOP);
        send_encode(-128, 0, F_END | F_STOP);
        // fill the pipe against a long output stall
        hold_request = 1'b1;
      end else if (p == 1) begin
        send_decode(8'h00, 8'h00, REC_END);
        send_decode(8'hFF, 8'hFF, REC_END);
        send_decode(8'h00, 8'h00, REC_TRIM);
        send_decode(8'h00, 8'h00, REC_STOP);
        send_decode(8'h00, 8'h00, REC_BASE);
        send_decode(8'hFF, 8'hFF, 8'hFF);
        send_decode(8'hA5, 8'hA5, 8'h24);
        send_decode(8'h5A, 8'h5A, 8'h18);
        send_decode(8'h5A, 8'h5A, 8'hDB);
        send_decode(8'h00, 8'h00, 8'hB3);
      end
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (codec_mode == MODE_ENCODE) begin
          send_encode(random_disp(), random_disp(),
                      ($urandom_range(0, 2) == 0) ? 4'd0 : 4'($urandom_range(0, 15)));
        end else begin
          case ($urandom_range(0, 7))
            0, 1, 2, 3: begin
              // decode a record that a valid encode would produce
              w.dx = 8'(int'($urandom_range(0, 242)) - 121);
              w.dy = 8'(int'($urandom_range(0, 242)) - 121);
              w.flags = 4'($urandom_range(0, 15));
              w.b0 = '0;
              w.b1 = '0;
              w.b2 = '0;
              r = sb.convert_word(w, MODE_ENCODE);
              send_decode(r.ob0, r.ob1, r.ob2);
            end
            4: send_decode(8'($urandom), 8'($urandom), REC_END);
            default: send_decode(8'($urandom), 8'($urandom), 8'($urandom));
          endcase
        end
      end
      s_axis_tvalid <= 1'b0;
      while (sb.pending_records.size() != 0) @(posedge clk);
      repeat (PIPE_DRAIN) @(posedge clk);
    end
    if (sb.all_matched()) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/btsc_pkg.sv
design/balanced_ternary_stitch_codec.sv
verif/testbench.sv
